/* rtl/core/assert_macros.svh */
// Assertion macros used by the port-level checker file.
// Needs only a clock and a disable condition at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define AST_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define AST_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/core/dccl_pkg.sv */
// Package for the DHCP client controller: codes, beat types, reset values.
// No dependencies.
package dccl_pkg;

   localparam int unsigned RSP_DEPTH = 4;
   localparam logic [31:0] FIXED_ADDR = 32'hC0A8_017B;

   localparam logic [3:0] RST_RETRY_LIMIT = 4'd4;
   localparam logic [7:0] RST_DISCOVER_PERIOD = 8'd15;
   localparam logic [7:0] RST_REQUEST_TIMEOUT = 8'd15;
   localparam logic [7:0] RST_PROBE_WAIT = 8'd15;
   localparam logic [7:0] RST_DECLINE_BACKOFF = 8'd15;
   localparam logic [7:0] RST_RENEW_PERIOD = 8'd10;

   typedef enum logic [3:0] {
      OP_TICK = 4'd0, OP_OFFER = 4'd1, OP_ACK = 4'd2, OP_ARP = 4'd3, OP_POLL = 4'd4,
      OP_ENABLE = 4'd5, OP_DISABLE = 4'd6, OP_RELEASE = 4'd7, OP_RENEW = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      MSG_NONE = 3'd0, MSG_DISCOVER = 3'd1, MSG_REQUEST = 3'd2, MSG_DECLINE = 3'd3,
      MSG_RELEASE = 3'd4, MSG_PROBE = 3'd5
   } msg_type;

   typedef enum logic [2:0] {
      ST_DISABLED = 3'd0, ST_INIT = 3'd1, ST_SELECTING = 3'd2, ST_REQUESTING = 3'd3,
      ST_TESTING = 3'd4, ST_BOUND = 3'd5, ST_RENEWING = 3'd6, ST_REBINDING = 3'd7
   } state_type;

   typedef enum logic [2:0] {
      CSR_RETRY_LIMIT = 3'd0, CSR_DISCOVER_PERIOD = 3'd1, CSR_REQUEST_TIMEOUT = 3'd2,
      CSR_PROBE_WAIT = 3'd3, CSR_DECLINE_BACKOFF = 3'd4, CSR_RENEW_PERIOD = 3'd5
   } csr_type;

   // pending flag bit positions
   localparam int unsigned PF_DISC = 0;
   localparam int unsigned PF_REQ  = 1;
   localparam int unsigned PF_REL  = 2;
   localparam int unsigned PF_ARP  = 3;
   localparam int unsigned PF_CONF = 4;

   typedef struct packed {
      logic [3:0]  operation;
      logic [31:0] offered_ip;
      logic [31:0] server_ip;
      logic        lease_present;
      logic [31:0] lease_seconds;
      logic        arp_to_us;
      logic [31:0] arp_sender_ip;
   } req_type;

   typedef struct packed {
      logic [2:0]  message;
      logic        with_requested_ip;
      logic        with_server_id;
      logic        unicast;
      logic [31:0] client_addr_field;
      logic [31:0] target_ip;
      logic [31:0] server_ip_out;
      logic [2:0]  client_state;
      logic [31:0] assigned_ip;
      logic [31:0] lease_out;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } res_pair_type;

endpackage

/* rtl/core/dccl_engine.sv */
// Client state, timers and config registers; one event per accepted beat.
// Depends on dccl_pkg.
module dccl_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  dccl_pkg::req_type      req,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [7:0]             csr_wdata,
   output dccl_pkg::res_pair_type res
);

   logic [3:0]  retry_ff;
   logic [7:0]  disc_per_ff, req_to_ff, probe_ff, backoff_ff, renew_per_ff;

   logic [2:0]  mode_ff, mode_in;
   logic [4:0]  pend_ff, pend_in;
   logic        en_ff, en_in;
   logic [3:0]  tries_ff, tries_in;
   logic [31:0] offer_ff, offer_in, server_ff, server_in, cur_ff, cur_in, lease_ff, lease_in;
   logic [31:0] lt_ff [3];
   logic [31:0] lt_in [3];
   logic [7:0]  st_ff [6];
   logic [7:0]  st_in [6];
   logic [8:0]  act_ff, act_in;
   logic [8:0]  fired;
   logic [34:0] lease7;
   logic [1:0]  n;
   dccl_pkg::rsp_type r0, r1;

   function automatic dccl_pkg::rsp_type mk(input logic [2:0] msg, input logic rq,
         input logic sid, input logic [2:0] md, input logic [31:0] ci,
         input logic [31:0] tg, input logic [31:0] sv);
      dccl_pkg::rsp_type r;
      r = '0;
      r.message = msg;
      r.with_requested_ip = rq;
      r.with_server_id = sid;
      r.unicast = (md == dccl_pkg::ST_BOUND) || (md == dccl_pkg::ST_RENEWING);
      r.client_addr_field = ci;
      r.target_ip = tg;
      r.server_ip_out = sv;
      return r;
   endfunction

   function automatic dccl_pkg::rsp_type mk_req(input logic [2:0] md, input logic [31:0] ofr,
         input logic [31:0] sv);
      logic rq, sid;
      rq = (md != dccl_pkg::ST_RENEWING) && (md != dccl_pkg::ST_BOUND);
      sid = rq && (md != dccl_pkg::ST_REBINDING);
      return mk(dccl_pkg::MSG_REQUEST, rq, sid, md, ofr, ofr, sv);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff <= dccl_pkg::RST_RETRY_LIMIT;
         disc_per_ff <= dccl_pkg::RST_DISCOVER_PERIOD;
         req_to_ff <= dccl_pkg::RST_REQUEST_TIMEOUT;
         probe_ff <= dccl_pkg::RST_PROBE_WAIT;
         backoff_ff <= dccl_pkg::RST_DECLINE_BACKOFF;
         renew_per_ff <= dccl_pkg::RST_RENEW_PERIOD;
      end else if (csr_we) begin
         case (csr_index)
            dccl_pkg::CSR_RETRY_LIMIT:     retry_ff <= csr_wdata[3:0];
            dccl_pkg::CSR_DISCOVER_PERIOD: disc_per_ff <= csr_wdata;
            dccl_pkg::CSR_REQUEST_TIMEOUT: req_to_ff <= csr_wdata;
            dccl_pkg::CSR_PROBE_WAIT:      probe_ff <= csr_wdata;
            dccl_pkg::CSR_DECLINE_BACKOFF: backoff_ff <= csr_wdata;
            dccl_pkg::CSR_RENEW_PERIOD:    renew_per_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in = mode_ff; pend_in = pend_ff; en_in = en_ff; tries_in = tries_ff;
      offer_in = offer_ff; server_in = server_ff; cur_in = cur_ff; lease_in = lease_ff;
      lt_in = lt_ff; st_in = st_ff; act_in = act_ff;
      fired = '0; lease7 = '0; n = 2'd0; r0 = '0; r1 = '0;
      if (fire) begin
         case (req.operation)
            dccl_pkg::OP_TICK: begin
               for (int i = 0; i < 3; i++) begin
                  if (act_in[i]) begin
                     lt_in[i] = lt_in[i] - 32'd1;
                     if (lt_in[i] == 32'd0) begin
                        fired[i] = 1'b1; act_in[i] = 1'b0;
                     end
                  end
               end
               for (int i = 0; i < 6; i++) begin
                  if (act_in[3+i]) begin
                     st_in[i] = st_in[i] - 8'd1;
                     if (st_in[i] == 8'd0) begin
                        fired[3+i] = 1'b1;
                        if (i == 0) begin
                           st_in[i] = disc_per_ff; act_in[3+i] = |disc_per_ff;
                        end else if (i == 4 || i == 5) begin
                           st_in[i] = renew_per_ff; act_in[3+i] = |renew_per_ff;
                        end else begin
                           act_in[3+i] = 1'b0;
                        end
                     end
                  end
               end
               if (fired[0]) begin
                  pend_in[dccl_pkg::PF_REQ] = 1'b1; mode_in = dccl_pkg::ST_RENEWING;
                  st_in[4] = renew_per_ff; act_in[7] = |renew_per_ff;
               end
               if (fired[1]) begin
                  pend_in[dccl_pkg::PF_REQ] = 1'b1; mode_in = dccl_pkg::ST_REBINDING;
                  st_in[5] = renew_per_ff; act_in[8] = |renew_per_ff;
               end
               if (fired[2]) begin
                  pend_in[dccl_pkg::PF_REL] = 1'b1;
                  if (en_in) begin
                     mode_in = dccl_pkg::ST_INIT; pend_in[dccl_pkg::PF_DISC] = 1'b1;
                  end else begin
                     mode_in = dccl_pkg::ST_DISABLED;
                  end
               end
               if (fired[3]) begin
                  mode_in = dccl_pkg::ST_INIT; pend_in[dccl_pkg::PF_DISC] = 1'b1;
               end
               if (fired[4]) begin
                  if (tries_in < retry_ff) begin
                     mode_in = dccl_pkg::ST_SELECTING; pend_in[dccl_pkg::PF_REQ] = 1'b1;
                     tries_in = tries_in + 4'd1;
                  end else begin
                     mode_in = dccl_pkg::ST_INIT; pend_in[dccl_pkg::PF_DISC] = 1'b1;
                     tries_in = 4'd0;
                  end
               end
               if (fired[5]) begin
                  cur_in = offer_in; mode_in = dccl_pkg::ST_BOUND;
               end
               if (fired[6]) begin
                  mode_in = dccl_pkg::ST_SELECTING; pend_in[dccl_pkg::PF_REQ] = 1'b1;
               end
               if (fired[7] || fired[8]) pend_in[dccl_pkg::PF_REQ] = 1'b1;
            end
            dccl_pkg::OP_OFFER: begin
               offer_in = req.offered_ip;
               server_in = req.server_ip;
               pend_in[dccl_pkg::PF_DISC] = 1'b0;
               pend_in[dccl_pkg::PF_REQ] = 1'b1;
            end
            dccl_pkg::OP_ACK: begin
               pend_in[dccl_pkg::PF_ARP] = 1'b1;
               if (mode_in == dccl_pkg::ST_RENEWING) begin
                  act_in[7] = 1'b0; st_in[4] = 8'd0;
               end else if (mode_in == dccl_pkg::ST_REBINDING) begin
                  act_in[8] = 1'b0; st_in[5] = 8'd0;
               end
               if (req.lease_present) lease_in = req.lease_seconds;
               // 7/8 of the lease: (8x - x) / 8
               lease7 = {lease_in, 3'b000} - {3'b000, lease_in};
               lt_in[0] = {1'b0, lease_in[31:1]};
               lt_in[1] = lease7[34:3];
               lt_in[2] = lease_in;
               act_in[0] = |lt_in[0];
               act_in[1] = |lt_in[1];
               act_in[2] = |lt_in[2];
               if (mode_in == dccl_pkg::ST_REQUESTING) begin
                  st_in[2] = probe_ff; act_in[5] = |probe_ff;
               end else begin
                  cur_in = offer_in; mode_in = dccl_pkg::ST_BOUND;
               end
            end
            dccl_pkg::OP_ARP: begin
               if (req.arp_to_us && req.arp_sender_ip == cur_in) begin
                  pend_in[dccl_pkg::PF_CONF] = 1'b1;
                  act_in[5] = 1'b0; st_in[2] = 8'd0;
               end
            end
            dccl_pkg::OP_POLL: begin
               if (pend_in[dccl_pkg::PF_REL]) begin
                  r0 = mk(dccl_pkg::MSG_RELEASE, 1'b0, 1'b1, mode_in, offer_in, 32'd0,
                          server_in);
                  n = 2'd1;
                  offer_in = dccl_pkg::FIXED_ADDR;
                  server_in = 32'd0;
                  cur_in = dccl_pkg::FIXED_ADDR;
                  if (mode_in != dccl_pkg::ST_INIT) en_in = 1'b0;
                  pend_in[dccl_pkg::PF_REL] = 1'b0;
               end
               case (mode_in)
                  dccl_pkg::ST_INIT: begin
                     if (pend_in[dccl_pkg::PF_DISC]) begin
                        st_in[0] = disc_per_ff; act_in[3] = |disc_per_ff;
                        r1 = mk(dccl_pkg::MSG_DISCOVER, 1'b1, 1'b0, mode_in, 32'd0,
                                dccl_pkg::FIXED_ADDR, server_in);
                        n = n + 2'd1;
                        mode_in = dccl_pkg::ST_SELECTING;
                        pend_in[dccl_pkg::PF_DISC] = 1'b0;
                     end
                  end
                  dccl_pkg::ST_SELECTING: begin
                     if (pend_in[dccl_pkg::PF_REQ]) begin
                        act_in[3] = 1'b0; st_in[0] = 8'd0;
                        st_in[1] = req_to_ff; act_in[4] = |req_to_ff;
                        r1 = mk_req(mode_in, offer_in, server_in);
                        n = n + 2'd1;
                        mode_in = dccl_pkg::ST_REQUESTING;
                        pend_in[dccl_pkg::PF_REQ] = 1'b0;
                     end
                  end
                  dccl_pkg::ST_REQUESTING: begin
                     if (pend_in[dccl_pkg::PF_ARP]) begin
                        act_in[4] = 1'b0; st_in[1] = 8'd0;
                        r1 = mk(dccl_pkg::MSG_PROBE, 1'b0, 1'b0, mode_in, 32'd0, offer_in,
                                server_in);
                        n = n + 2'd1;
                        mode_in = dccl_pkg::ST_TESTING;
                        pend_in[dccl_pkg::PF_ARP] = 1'b0;
                     end
                  end
                  dccl_pkg::ST_TESTING: begin
                     if (pend_in[dccl_pkg::PF_CONF]) begin
                        act_in[5] = 1'b0; st_in[2] = 8'd0;
                        st_in[3] = backoff_ff; act_in[6] = |backoff_ff;
                        act_in[2:0] = 3'b000;
                        lt_in[0] = 32'd0; lt_in[1] = 32'd0; lt_in[2] = 32'd0;
                        r1 = mk(dccl_pkg::MSG_DECLINE, 1'b1, 1'b1, mode_in, 32'd0, offer_in,
                                server_in);
                        n = n + 2'd1;
                        pend_in[dccl_pkg::PF_CONF] = 1'b0;
                     end
                  end
                  dccl_pkg::ST_BOUND: begin
                     if (pend_in[dccl_pkg::PF_REQ]) begin
                        r1 = mk_req(mode_in, offer_in, server_in);
                        n = n + 2'd1;
                        pend_in[dccl_pkg::PF_REQ] = 1'b0;
                     end
                     pend_in[dccl_pkg::PF_ARP] = 1'b0;
                  end
                  dccl_pkg::ST_RENEWING, dccl_pkg::ST_REBINDING: begin
                     if (pend_in[dccl_pkg::PF_REQ]) begin
                        r1 = mk_req(mode_in, offer_in, server_in);
                        n = n + 2'd1;
                        pend_in[dccl_pkg::PF_REQ] = 1'b0;
                     end else if (pend_in[dccl_pkg::PF_ARP]) begin
                        mode_in = dccl_pkg::ST_BOUND;
                        pend_in[dccl_pkg::PF_ARP] = 1'b0;
                     end
                  end
                  default: ;
               endcase
               // a lone state message moves to the first slot
               if (!pend_ff[dccl_pkg::PF_REL]) r0 = r1;
            end
            dccl_pkg::OP_ENABLE: begin
               if (mode_in == dccl_pkg::ST_DISABLED) begin
                  pend_in = 5'd0;
                  pend_in[dccl_pkg::PF_DISC] = 1'b1;
                  st_in[0] = disc_per_ff; act_in[3] = |disc_per_ff;
                  mode_in = dccl_pkg::ST_INIT;
               end
               en_in = 1'b1;
            end
            dccl_pkg::OP_DISABLE: begin
               pend_in[dccl_pkg::PF_REL] = 1'b1;
               en_in = 1'b0;
               mode_in = dccl_pkg::ST_DISABLED;
            end
            dccl_pkg::OP_RELEASE: begin
               if (en_in) begin
                  act_in = '0;
                  for (int i = 0; i < 3; i++) lt_in[i] = 32'd0;
                  for (int i = 0; i < 6; i++) st_in[i] = 8'd0;
                  pend_in[dccl_pkg::PF_REL] = 1'b1;
                  mode_in = dccl_pkg::ST_DISABLED;
               end
            end
            dccl_pkg::OP_RENEW: begin
               if (en_in && mode_in == dccl_pkg::ST_BOUND) pend_in[dccl_pkg::PF_REQ] = 1'b1;
            end
            default: ;
         endcase
      end
      if (n == 2'd0) begin
         r0 = '0;
         n = 2'd1;
      end
      r0.client_state = mode_in; r0.assigned_ip = cur_in; r0.lease_out = lease_in;
      r1.client_state = mode_in; r1.assigned_ip = cur_in; r1.lease_out = lease_in;
      r0.last = (n == 2'd1);
      r1.last = 1'b1;
      res.two = (n == 2'd2);
      res.first = r0;
      res.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= dccl_pkg::ST_DISABLED; pend_ff <= '0; en_ff <= 1'b1; tries_ff <= '0;
         offer_ff <= '0; server_ff <= '0; cur_ff <= '0; lease_ff <= '0;
         lt_ff <= '{default: '0}; st_ff <= '{default: '0}; act_ff <= '0;
      end else begin
         mode_ff <= mode_in; pend_ff <= pend_in; en_ff <= en_in; tries_ff <= tries_in;
         offer_ff <= offer_in; server_ff <= server_in; cur_ff <= cur_in;
         lease_ff <= lease_in; lt_ff <= lt_in; st_ff <= st_in; act_ff <= act_in;
      end
   end

endmodule

/* rtl/core/dccl_rsp_fifo.sv */
// Result queue: takes one or two beats per cycle, hands out one per cycle while rsp_stall is low.
// Depends on dccl_pkg.
module dccl_rsp_fifo #(
   parameter int unsigned DEPTH = dccl_pkg::RSP_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dccl_pkg::res_pair_type pair,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dccl_pkg::rsp_type      rsp_data
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LASTP = PW'(DEPTH - 1);

   dccl_pkg::rsp_type mem [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in, wp1;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic pop;

   assign wp1 = (wp_ff == LASTP) ? '0 : wp_ff + PW'(1);
   assign pop = rsp_valid && !rsp_stall;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data = mem[rp_ff];
   // need space for two beats
   assign room = (cnt_ff <= CW'(DEPTH - 2));

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         if (pair.two) begin
            wp_in = (wp1 == LASTP) ? '0 : wp1 + PW'(1);
            cnt_in = cnt_in + CW'(2);
         end else begin
            wp_in = wp1;
            cnt_in = cnt_in + CW'(1);
         end
      end
      if (pop) begin
         rp_in = (rp_ff == LASTP) ? '0 : rp_ff + PW'(1);
         cnt_in = cnt_in - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wp_ff] <= pair.first;
         if (pair.two) mem[wp1] <= pair.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

endmodule

/* rtl/core/dhcp_client_controller_top.sv */
// Top level of the DHCP client controller.
// Depends on dccl_pkg, dccl_engine, dccl_rsp_fifo.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_data (req_type)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_data (rsp_type)
//  csr     | in        | csr_we              | csr_index, csr_wdata
//
// One event beat per cycle while req_stall is low; its results enter the queue at the
// same edge and leave on rsp in order, one beat per cycle while rsp_stall is low (a poll may give two).
// req_stall rises when the result queue has room for fewer than two beats.
// Synchronous reset empties the queue and restores state and registers.
module dhcp_client_controller_top #(
   parameter int unsigned RSP_DEPTH = dccl_pkg::RSP_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dccl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dccl_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   logic fire, room;
   dccl_pkg::res_pair_type pair;

   assign req_stall = !room;
   assign fire = req_valid && room;

   dccl_engine u_engine (
      .clock(clock), .reset(reset), .fire(fire), .req(req_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata), .res(pair)
   );

   dccl_rsp_fifo #(.DEPTH(RSP_DEPTH)) u_fifo (
      .clock(clock), .reset(reset), .push(fire), .pair(pair), .room(room),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

/* rtl/core/dccl_checker.sv */
// Port-level checks for the DHCP client controller, bound to the top level.
// Depends on dccl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dccl_assertions (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dccl_pkg::rsp_type rsp_data
);

   logic hold_cond, none_beat, disc_beat, disc_ok;

   assign hold_cond = rsp_valid && rsp_stall && !reset;
   assign none_beat = rsp_valid && (rsp_data.message == dccl_pkg::MSG_NONE);
   assign disc_beat = rsp_valid && (rsp_data.message == dccl_pkg::MSG_DISCOVER);
   assign disc_ok = (rsp_data.target_ip == dccl_pkg::FIXED_ADDR) && rsp_data.with_requested_ip;

   `AST_NEXT(a_rst_empty, clock, 1'b0, reset, !rsp_valid)
   `AST_NEXT(a_rsp_hold, clock, reset, hold_cond, rsp_valid && $stable(rsp_data))
   `AST_IMPLY(a_none_last, clock, reset, none_beat, rsp_data.last)
   `AST_IMPLY(a_disc_fmt, clock, reset, disc_beat, disc_ok)

endmodule

bind dhcp_client_controller_top dccl_assertions u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);

/* dv/dccl_checker.sv */
// Checker for the DHCP client controller: watches req/rsp/csr, predicts results.
// Depends on dccl_pkg.
`timescale 1ns / 100ps
module dccl_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  dccl_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  dccl_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output int                fail_count,
   output int                waiting_count
);
   // registers
   logic [3:0] retry_limit;
   logic [7:0] disc_per, req_tmo, probe_wt, decl_bo, renew_per;
   // client state
   dccl_pkg::state_type mode;
   logic [4:0] pend;
   logic       enabled;
   logic [3:0] tries;
   logic [31:0] offer_a, server_a, cur_a, lease;
   logic [31:0] lt [3];
   logic [7:0]  sht [6];
   logic [8:0]  act;

   localparam int LT_T1 = 0, LT_T2 = 1, LT_END = 2;
   localparam int SH_DISC = 0, SH_REQ = 1, SH_PROBE = 2, SH_BACKOFF = 3,
      SH_RENEW = 4, SH_REBIND = 5;

   dccl_pkg::rsp_type expected_rsps[$];

   function automatic void model_reset();
      retry_limit = dccl_pkg::RST_RETRY_LIMIT; disc_per = dccl_pkg::RST_DISCOVER_PERIOD;
      req_tmo = dccl_pkg::RST_REQUEST_TIMEOUT; probe_wt = dccl_pkg::RST_PROBE_WAIT;
      decl_bo = dccl_pkg::RST_DECLINE_BACKOFF; renew_per = dccl_pkg::RST_RENEW_PERIOD;
      mode = dccl_pkg::ST_DISABLED; pend = '0; enabled = 1'b1; tries = '0;
      offer_a = '0; server_a = '0; cur_a = '0; lease = '0;
      foreach (lt[i]) lt[i] = '0;
      foreach (sht[i]) sht[i] = '0;
      act = '0;
      expected_rsps.delete();
   endfunction

   function automatic void start_lt(int i, logic [31:0] v);
      lt[i] = v;
      act[i] = (v != 0);
   endfunction

   function automatic void start_sh(int i, logic [7:0] v);
      sht[i] = v;
      act[3+i] = (v != 0);
   endfunction

   function automatic void stop_sh(int i);
      act[3+i] = 1'b0;
      sht[i] = '0;
   endfunction

   function automatic void run_tick();
      logic [8:0] fired;
      fired = '0;
      for (int i = 0; i < 3; i++)
         if (act[i]) begin
            lt[i] = lt[i] - 32'd1;
            if (lt[i] == 0) begin
               fired[i] = 1'b1;
               act[i] = 1'b0;
            end
         end
      for (int i = 0; i < 6; i++)
         if (act[3+i]) begin
            sht[i] = sht[i] - 8'd1;
            if (sht[i] == 0) begin
               fired[3+i] = 1'b1;
               if (i == SH_DISC) start_sh(i, disc_per);
               else if (i == SH_RENEW || i == SH_REBIND) start_sh(i, renew_per);
               else act[3+i] = 1'b0;
            end
         end
      if (fired[LT_T1]) begin
         pend[dccl_pkg::PF_REQ] = 1; mode = dccl_pkg::ST_RENEWING;
         start_sh(SH_RENEW, renew_per);
      end
      if (fired[LT_T2]) begin
         pend[dccl_pkg::PF_REQ] = 1; mode = dccl_pkg::ST_REBINDING;
         start_sh(SH_REBIND, renew_per);
      end
      if (fired[LT_END]) begin
         pend[dccl_pkg::PF_REL] = 1;
         if (enabled) begin
            mode = dccl_pkg::ST_INIT; pend[dccl_pkg::PF_DISC] = 1;
         end else mode = dccl_pkg::ST_DISABLED;
      end
      if (fired[3+SH_DISC]) begin
         mode = dccl_pkg::ST_INIT; pend[dccl_pkg::PF_DISC] = 1;
      end
      if (fired[3+SH_REQ]) begin
         if (tries < retry_limit) begin
            mode = dccl_pkg::ST_SELECTING; pend[dccl_pkg::PF_REQ] = 1; tries = tries + 4'd1;
         end else begin
            mode = dccl_pkg::ST_INIT; pend[dccl_pkg::PF_DISC] = 1; tries = '0;
         end
      end
      if (fired[3+SH_PROBE]) begin
         cur_a = offer_a; mode = dccl_pkg::ST_BOUND;
      end
      if (fired[3+SH_BACKOFF]) begin
         mode = dccl_pkg::ST_SELECTING; pend[dccl_pkg::PF_REQ] = 1;
      end
      if (fired[3+SH_RENEW] || fired[3+SH_REBIND]) pend[dccl_pkg::PF_REQ] = 1;
   endfunction

   function automatic dccl_pkg::rsp_type make_msg(dccl_pkg::msg_type m, logic rq, logic sid,
                                                  logic [31:0] ci, logic [31:0] tg);
      dccl_pkg::rsp_type r;
      r = '0;
      r.message = m;
      r.with_requested_ip = rq;
      r.with_server_id = sid;
      r.unicast = (mode == dccl_pkg::ST_BOUND || mode == dccl_pkg::ST_RENEWING);
      r.client_addr_field = ci;
      r.target_ip = tg;
      r.server_ip_out = server_a;
      return r;
   endfunction

   function automatic dccl_pkg::rsp_type make_request();
      return make_msg(dccl_pkg::MSG_REQUEST,
         mode != dccl_pkg::ST_RENEWING && mode != dccl_pkg::ST_BOUND,
         mode != dccl_pkg::ST_REBINDING && mode != dccl_pkg::ST_RENEWING &&
            mode != dccl_pkg::ST_BOUND,
         offer_a, offer_a);
   endfunction

   function automatic void run_poll(ref dccl_pkg::rsp_type outs[$]);
      if (pend[dccl_pkg::PF_REL]) begin
         outs.push_back(make_msg(dccl_pkg::MSG_RELEASE, 1'b0, 1'b1, offer_a, '0));
         offer_a = dccl_pkg::FIXED_ADDR; server_a = '0; cur_a = dccl_pkg::FIXED_ADDR;
         if (mode != dccl_pkg::ST_INIT) enabled = 1'b0;
         pend[dccl_pkg::PF_REL] = 0;
      end
      case (mode)
         dccl_pkg::ST_INIT: if (pend[dccl_pkg::PF_DISC]) begin
            start_sh(SH_DISC, disc_per);
            outs.push_back(make_msg(dccl_pkg::MSG_DISCOVER, 1'b1, 1'b0, '0,
               dccl_pkg::FIXED_ADDR));
            mode = dccl_pkg::ST_SELECTING; pend[dccl_pkg::PF_DISC] = 0;
         end
         dccl_pkg::ST_SELECTING: if (pend[dccl_pkg::PF_REQ]) begin
            stop_sh(SH_DISC);
            start_sh(SH_REQ, req_tmo);
            outs.push_back(make_request());
            mode = dccl_pkg::ST_REQUESTING; pend[dccl_pkg::PF_REQ] = 0;
         end
         dccl_pkg::ST_REQUESTING: if (pend[dccl_pkg::PF_ARP]) begin
            stop_sh(SH_REQ);
            outs.push_back(make_msg(dccl_pkg::MSG_PROBE, 1'b0, 1'b0, '0, offer_a));
            mode = dccl_pkg::ST_TESTING; pend[dccl_pkg::PF_ARP] = 0;
         end
         dccl_pkg::ST_TESTING: if (pend[dccl_pkg::PF_CONF]) begin
            stop_sh(SH_PROBE);
            start_sh(SH_BACKOFF, decl_bo);
            for (int i = 0; i < 3; i++) begin
               act[i] = 1'b0; lt[i] = '0;
            end
            outs.push_back(make_msg(dccl_pkg::MSG_DECLINE, 1'b1, 1'b1, '0, offer_a));
            pend[dccl_pkg::PF_CONF] = 0;
         end
         dccl_pkg::ST_BOUND: begin
            if (pend[dccl_pkg::PF_REQ]) begin
               outs.push_back(make_request()); pend[dccl_pkg::PF_REQ] = 0;
            end
            pend[dccl_pkg::PF_ARP] = 0;
         end
         dccl_pkg::ST_RENEWING, dccl_pkg::ST_REBINDING: begin
            if (pend[dccl_pkg::PF_REQ]) begin
               outs.push_back(make_request()); pend[dccl_pkg::PF_REQ] = 0;
            end else if (pend[dccl_pkg::PF_ARP]) begin
               mode = dccl_pkg::ST_BOUND; pend[dccl_pkg::PF_ARP] = 0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_event(dccl_pkg::req_type d);
      dccl_pkg::rsp_type outs[$];
      logic [63:0] prod;
      case (d.operation)
         dccl_pkg::OP_TICK: run_tick();
         dccl_pkg::OP_OFFER: begin
            offer_a = d.offered_ip; server_a = d.server_ip;
            pend[dccl_pkg::PF_DISC] = 0; pend[dccl_pkg::PF_REQ] = 1;
         end
         dccl_pkg::OP_ACK: begin
            pend[dccl_pkg::PF_ARP] = 1;
            if (mode == dccl_pkg::ST_RENEWING) stop_sh(SH_RENEW);
            else if (mode == dccl_pkg::ST_REBINDING) stop_sh(SH_REBIND);
            if (d.lease_present) lease = d.lease_seconds;
            prod = {32'd0, lease} * 64'd7;
            start_lt(LT_T1, lease >> 1);
            start_lt(LT_T2, prod[34:3]);
            start_lt(LT_END, lease);
            if (mode == dccl_pkg::ST_REQUESTING) start_sh(SH_PROBE, probe_wt);
            else begin
               cur_a = offer_a; mode = dccl_pkg::ST_BOUND;
            end
         end
         dccl_pkg::OP_ARP: if (d.arp_to_us && d.arp_sender_ip == cur_a) begin
            pend[dccl_pkg::PF_CONF] = 1; stop_sh(SH_PROBE);
         end
         dccl_pkg::OP_POLL: run_poll(outs);
         dccl_pkg::OP_ENABLE: begin
            if (mode == dccl_pkg::ST_DISABLED) begin
               pend = '0; pend[dccl_pkg::PF_DISC] = 1;
               start_sh(SH_DISC, disc_per);
               mode = dccl_pkg::ST_INIT;
            end
            enabled = 1'b1;
         end
         dccl_pkg::OP_DISABLE: begin
            pend[dccl_pkg::PF_REL] = 1; enabled = 1'b0; mode = dccl_pkg::ST_DISABLED;
         end
         dccl_pkg::OP_RELEASE: if (enabled) begin
            act = '0;
            foreach (lt[i]) lt[i] = '0;
            foreach (sht[i]) sht[i] = '0;
            pend[dccl_pkg::PF_REL] = 1; mode = dccl_pkg::ST_DISABLED;
         end
         dccl_pkg::OP_RENEW:
            if (enabled && mode == dccl_pkg::ST_BOUND) pend[dccl_pkg::PF_REQ] = 1;
         default: ;
      endcase
      if (outs.size() == 0) outs.push_back('0);
      foreach (outs[k]) begin
         outs[k].client_state = mode;
         outs[k].assigned_ip = cur_a;
         outs[k].lease_out = lease;
         outs[k].last = (k == outs.size() - 1);
         expected_rsps.push_back(outs[k]);
      end
   endfunction

   function automatic void compare_rsp(dccl_pkg::rsp_type a);
      dccl_pkg::rsp_type e;
      if (expected_rsps.size() == 0) begin
         $error("result beat with nothing expected: %h", a);
         fail_count++;
         return;
      end
      e = expected_rsps.pop_front();
      if (a !== e) begin
         fail_count++;
         if (a.message !== e.message)
            $error("message exp %0d got %0d", e.message, a.message);
         if (a.with_requested_ip !== e.with_requested_ip)
            $error("with_requested_ip exp %0b got %0b", e.with_requested_ip,
               a.with_requested_ip);
         if (a.with_server_id !== e.with_server_id)
            $error("with_server_id exp %0b got %0b", e.with_server_id, a.with_server_id);
         if (a.unicast !== e.unicast)
            $error("unicast exp %0b got %0b", e.unicast, a.unicast);
         if (a.client_addr_field !== e.client_addr_field)
            $error("client_addr_field exp %h got %h", e.client_addr_field,
               a.client_addr_field);
         if (a.target_ip !== e.target_ip)
            $error("target_ip exp %h got %h", e.target_ip, a.target_ip);
         if (a.server_ip_out !== e.server_ip_out)
            $error("server_ip_out exp %h got %h", e.server_ip_out, a.server_ip_out);
         if (a.client_state !== e.client_state)
            $error("client_state exp %0d got %0d", e.client_state, a.client_state);
         if (a.assigned_ip !== e.assigned_ip)
            $error("assigned_ip exp %h got %h", e.assigned_ip, a.assigned_ip);
         if (a.lease_out !== e.lease_out)
            $error("lease_out exp %h got %h", e.lease_out, a.lease_out);
         if (a.last !== e.last)
            $error("last exp %0b got %0b", e.last, a.last);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         model_reset();
         fail_count = 0;
      end else begin
         // compare first: a beat leaving now was predicted at an earlier edge
         if (rsp_valid && !rsp_stall) compare_rsp(rsp_data);
         if (csr_we)
            case (dccl_pkg::csr_type'(csr_index))
               dccl_pkg::CSR_RETRY_LIMIT: retry_limit = csr_wdata[3:0];
               dccl_pkg::CSR_DISCOVER_PERIOD: disc_per = csr_wdata;
               dccl_pkg::CSR_REQUEST_TIMEOUT: req_tmo = csr_wdata;
               dccl_pkg::CSR_PROBE_WAIT: probe_wt = csr_wdata;
               dccl_pkg::CSR_DECLINE_BACKOFF: decl_bo = csr_wdata;
               dccl_pkg::CSR_RENEW_PERIOD: renew_per = csr_wdata;
               default: ;
            endcase
         if (req_valid && !req_stall) predict_event(req_data);
      end
      waiting_count = expected_rsps.size();
   end
endmodule

/* dv/tb_top.sv */
// Testbench top for dhcp_client_controller_top: clock, reset, stimulus, verdict.
// Depends on dccl_pkg, dccl_checker and the RTL.
`timescale 1ns / 100ps
module tb_top;

   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   dccl_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   dccl_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;
   int      fail_count, waiting_count;
   int      cycle_count = 0;
   bit      calm = 1'b0;   // no idling on either side
   logic [31:0] last_offer = 32'h0A00_0005;

   always #1 clock = ~clock;

   dhcp_client_controller_top u_dut (.*);

   dccl_checker u_chk (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 12);

   // valid stays high after the beat is taken; the next send or drain moves it
   task automatic send_beat(dccl_pkg::req_type d);
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_op(dccl_pkg::op_type op);
      dccl_pkg::req_type d;
      d = '0;
      d.operation = op;
      d.offered_ip = $urandom;
      d.server_ip = $urandom;
      d.lease_present = 1'($urandom_range(1));
      d.lease_seconds = $urandom_range(60);
      d.arp_to_us = 1'($urandom_range(1));
      d.arp_sender_ip = $urandom;
      if (op == dccl_pkg::OP_OFFER) last_offer = d.offered_ip;
      if (op == dccl_pkg::OP_ARP && $urandom_range(1)) begin
         // hit the address under probe or in use
         d.arp_to_us = 1'b1;
         d.arp_sender_ip = last_offer;
      end
      send_beat(d);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (waiting_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(dccl_pkg::csr_type idx, logic [7:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
   endtask

   task automatic set_regs(logic [3:0] rl, logic [7:0] p);
      write_csr(dccl_pkg::CSR_RETRY_LIMIT, {4'd0, rl});
      write_csr(dccl_pkg::CSR_DISCOVER_PERIOD, p);
      write_csr(dccl_pkg::CSR_REQUEST_TIMEOUT, p);
      write_csr(dccl_pkg::CSR_PROBE_WAIT, p);
      write_csr(dccl_pkg::CSR_DECLINE_BACKOFF, p);
      write_csr(dccl_pkg::CSR_RENEW_PERIOD, p);
      csr_we <= 1'b0;
   endtask

   // one well-formed lease cycle with random noise mixed in
   task automatic lease_flow();
      dccl_pkg::op_type flow[$];
      flow = '{dccl_pkg::OP_ENABLE, dccl_pkg::OP_POLL, dccl_pkg::OP_OFFER,
               dccl_pkg::OP_POLL, dccl_pkg::OP_ACK, dccl_pkg::OP_POLL,
               dccl_pkg::OP_TICK, dccl_pkg::OP_TICK, dccl_pkg::OP_ARP,
               dccl_pkg::OP_POLL, dccl_pkg::OP_TICK, dccl_pkg::OP_POLL,
               dccl_pkg::OP_RENEW, dccl_pkg::OP_POLL, dccl_pkg::OP_ACK,
               dccl_pkg::OP_POLL};
      foreach (flow[i]) begin
         if ($urandom_range(9) == 0) send_op(dccl_pkg::op_type'($urandom_range(8)));
         send_op(flow[i]);
      end
   endtask

   initial begin
      dccl_pkg::req_type d;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: field extremes and every operation
      d = '1;
      d.operation = dccl_pkg::OP_OFFER;
      send_beat(d);
      d = '1;
      d.operation = dccl_pkg::OP_ACK;
      send_beat(d);
      d = '0;
      d.operation = dccl_pkg::OP_ACK;
      send_beat(d);
      for (int op = 0; op <= 8; op++) send_op(dccl_pkg::op_type'(op));
      d = '0;
      d.operation = dccl_pkg::OP_ARP;
      d.arp_to_us = 1'b1;
      d.arp_sender_ip = '1;
      send_beat(d);
      d.operation = 4'hF;   // unknown operation
      send_beat(d);
      send_op(dccl_pkg::OP_POLL);
      send_op(dccl_pkg::OP_POLL);
      drain();
      // zero periods: the period timers never start; the lease timers still run
      set_regs(4'd0, 8'd0);
      lease_flow();
      drain();
      set_regs(4'd15, 8'd255);
      lease_flow();
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         set_regs(4'($urandom_range(15)), 8'($urandom_range(1, 4)));
         calm = (phase == 2);
         for (int n = 0; n < 12; n++) begin
            if ($urandom_range(3) == 0)
               for (int k = 0; k < 4; k++)
                  send_op(dccl_pkg::op_type'($urandom_range(8)));
            else lease_flow();
            if (n == 5) drain();
         end
         drain();
      end
      calm = 1'b0;
      drain();
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
